>>> hdl/sti_pkg.sv
`timescale 1ns / 1ps
// Shared types for the sorted table: result status codes, the item kind and the
// per-cell control word. No dependencies.
package sti_pkg;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_NO_MATCH = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	// Broadcast to every cell in the cycle an item is applied.
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctl_t;

endpackage

>>> hdl/sorted_table_insert_remove.sv
`timescale 1ns / 1ps
// Sorted table with insert and remove. Keeps up to DEPTH signed values in
// ascending order in a row of cells; every cell compares its entry with the
// incoming value in parallel and shifts toward or away from its neighbor, so an
// item is applied in the cycle it is accepted and its status and new count
// appear on the registered output the next cycle. One item is taken per cycle
// whenever the output register is empty or being drained; the rate is set by
// the single compare-and-shift pass across the cell row. Inserting into a full
// table reports a drop, removing an absent value reports no match, and the
// count stays between 0 and DEPTH. Depends on sti_pkg and sti_cell.
module sorted_table_insert_remove #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [4:0]                    count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic                          accept;
	logic                          full;
	logic                          found;
	sti_pkg::cell_ctl_t            ctl;
	sti_pkg::status_t              status_d;
	logic [CW-1:0]                 used_d;
	logic [CW-1:0]                 used_q;
	logic                          out_valid_q;
	sti_pkg::status_t              status_q;
	logic [CW-1:0]                 count_q;
	logic [CW+4:0]                 count_wide;

	logic [DEPTH-1:0]                    cell_valid;
	logic [DEPTH-1:0]                    cell_ge;
	logic [DEPTH-1:0]                    cell_eq;
	logic signed [VALUE_WIDTH-1:0]       cell_entry [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (used_q == CW'(DEPTH));
	assign found    = |cell_eq;

	always_comb begin
		ctl      = '0;
		status_d = sti_pkg::ST_INSERTED;
		used_d   = used_q;
		unique case (sti_pkg::kind_t'(kind))
			sti_pkg::KIND_INSERT: begin
				if (full) begin
					status_d = sti_pkg::ST_FULL;
				end else begin
					ctl.insert = accept;
					status_d   = sti_pkg::ST_INSERTED;
					used_d     = used_q + CW'(1);
				end
			end
			sti_pkg::KIND_REMOVE: begin
				if (found) begin
					ctl.remove = accept;
					status_d   = sti_pkg::ST_REMOVED;
					used_d     = used_q - CW'(1);
				end else begin
					status_d = sti_pkg::ST_NO_MATCH;
				end
			end
			default: begin
				status_d = sti_pkg::ST_NO_MATCH;
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                          left_valid;
			logic                          left_ge;
			logic signed [VALUE_WIDTH-1:0] left_entry;
			logic signed [VALUE_WIDTH-1:0] right_entry;

			assign cell_valid[gi] = (used_q > CW'(gi));

			if (gi == 0) begin : g_first
				assign left_valid = 1'b1;
				assign left_ge    = 1'b0;
				assign left_entry = value;
			end else begin : g_mid
				assign left_valid = cell_valid[gi-1];
				assign left_ge    = cell_ge[gi-1];
				assign left_entry = cell_entry[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign right_entry = cell_entry[gi];
			end else begin : g_inner
				assign right_entry = cell_entry[gi+1];
			end

			sti_cell #(
				.VALUE_WIDTH (VALUE_WIDTH)
			) u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.item        (value),
				.cell_valid  (cell_valid[gi]),
				.left_valid  (left_valid),
				.left_ge     (left_ge),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.ge          (cell_ge[gi]),
				.eq          (cell_eq[gi]),
				.entry       (cell_entry[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				used_q      <= used_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			count_q  <= used_d;
		end
	end

	assign count_wide = {5'd0, count_q};
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign count      = count_wide[4:0];

endmodule

>>> hdl/sti_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted table: holds one entry, compares it against the
// broadcast item and holds, loads the item, or loads from its left or its right neighbor.
// Depends on sti_pkg.
module sti_cell #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  sti_pkg::cell_ctl_t            ctl,
	input  logic signed [VALUE_WIDTH-1:0] item,
	input  logic                          cell_valid,
	input  logic                          left_valid,
	input  logic                          left_ge,
	input  logic signed [VALUE_WIDTH-1:0] left_entry,
	input  logic signed [VALUE_WIDTH-1:0] right_entry,
	output logic                          ge,
	output logic                          eq,
	output logic signed [VALUE_WIDTH-1:0] entry
);

	logic signed [VALUE_WIDTH-1:0] entry_q;

	assign ge    = cell_valid && (entry_q >= item);
	assign eq    = cell_valid && (entry_q == item);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			// shift right behind the insert point, drop the item at the point itself
			if (left_ge) begin
				entry_q <= left_entry;
			end else if (left_valid && (ge || !cell_valid)) begin
				entry_q <= item;
			end
		end else if (ctl.remove) begin
			// close the gap from the first equal entry onward
			if (ge) begin
				entry_q <= right_entry;
			end
		end
	end

endmodule
